// ----- hw/rtl/dmarb_pkg.sv -----
// Shared types, codes and helpers for the DMA register bank.
`timescale 1ns / 1ps
`default_nettype none

package dmarb_pkg;

  localparam int IRQ_CH_W = 7;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_DONE  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    TGT_BASE  = 3'd0,
    TGT_BLOCK = 3'd1,
    TGT_CHAN  = 3'd2,
    TGT_DMA   = 3'd3,
    TGT_IRQ   = 3'd4
  } tgt_t;

  localparam logic [1:0] SYNC_ONESHOT = 2'd0;
  localparam logic [1:0] SYNC_PACED   = 2'd1;
  localparam logic [1:0] SYNC_LIST    = 2'd2;
  localparam logic [1:0] SYNC_KEEP    = 2'd3;

  // One input word as it sits in the stage register
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  target;
    logic [2:0]  channel;
    logic [31:0] wdata;
  } item_t;

  // Stored state of one channel
  typedef struct packed {
    logic        dir;
    logic        step;
    logic        chop;
    logic [1:0]  sync;
    logic [2:0]  dma_win;
    logic [2:0]  cpu_win;
    logic        en;
    logic        trig;
    logic [1:0]  spare;
    logic [23:0] base;
    logic [15:0] bsize;
    logic [15:0] bcount;
  } chan_t;

  // Summary of the addressed channel after the word is applied
  typedef struct packed {
    logic        active;
    logic        dir;
    logic        step;
    logic [1:0]  sync;
    logic [31:0] words;
  } chan_info_t;

  function automatic logic irq_status(input logic force_bit, input logic master,
                                      input logic [IRQ_CH_W-1:0] flags,
                                      input logic [IRQ_CH_W-1:0] enables);
    irq_status = force_bit | (master & (|(flags & enables)));
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dmarb_chan_regs.sv -----
// Per-channel register file with update, readback and channel summary.
`timescale 1ns / 1ps
`default_nettype none

module dmarb_chan_regs
  import dmarb_pkg::*;
#(
  parameter int NUM_CHANNELS = 7
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire item_t      item,
  input  wire logic       we,
  output logic [31:0]     rd_data,
  output chan_info_t      info
);

  chan_t chan_r [NUM_CHANNELS];
  chan_t cur;
  chan_t chan_nxt;
  logic  hit;

  // Select the addressed channel
  always_comb begin
    cur = '0;
    hit = 1'b0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (item.channel == 3'(i)) begin
        cur = chan_r[i];
        hit = 1'b1;
      end
    end
  end

  // Apply a write or a done event to the addressed channel
  always_comb begin
    chan_nxt = cur;
    case (item.kind)
      KIND_WRITE: begin
        case (item.target)
          TGT_BASE: chan_nxt.base = item.wdata[23:0];
          TGT_BLOCK: begin
            chan_nxt.bsize  = item.wdata[15:0];
            chan_nxt.bcount = item.wdata[31:16];
          end
          TGT_CHAN: begin
            chan_nxt.dir  = item.wdata[0];
            chan_nxt.step = item.wdata[1];
            chan_nxt.chop = item.wdata[8];
            if (item.wdata[10:9] != SYNC_KEEP) begin
              chan_nxt.sync    = item.wdata[10:9];
              chan_nxt.dma_win = item.wdata[18:16];
              chan_nxt.cpu_win = item.wdata[22:20];
              chan_nxt.en      = item.wdata[24];
              chan_nxt.trig    = item.wdata[28];
              chan_nxt.spare   = item.wdata[30:29];
            end
          end
          default: ;
        endcase
      end
      KIND_DONE: begin
        chan_nxt.en   = 1'b0;
        chan_nxt.trig = 1'b0;
      end
      default: ;
    endcase
  end

  // Write back the addressed channel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) chan_r[i] <= '0;
    end else if (we) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (item.channel == 3'(i)) chan_r[i] <= chan_nxt;
      end
    end
  end

  // Read the current contents of a channel register
  always_comb begin
    rd_data = '0;
    if (hit) begin
      case (item.target)
        TGT_BASE:  rd_data = {8'b0, cur.base};
        TGT_BLOCK: rd_data = {cur.bcount, cur.bsize};
        TGT_CHAN:  rd_data = {1'b0, cur.spare, cur.trig, 3'b0, cur.en, 1'b0, cur.cpu_win,
                              1'b0, cur.dma_win, 5'b0, cur.sync, cur.chop, 6'b0,
                              cur.step, cur.dir};
        default:   rd_data = '0;
      endcase
    end
  end

  // Summarize the channel as it stands after the word
  always_comb begin
    info = '0;
    if (hit) begin
      info.active = chan_nxt.en & ((chan_nxt.sync != SYNC_ONESHOT) | chan_nxt.trig);
      info.dir    = chan_nxt.dir;
      info.step   = chan_nxt.step;
      info.sync   = chan_nxt.sync;
      case (chan_nxt.sync)
        SYNC_ONESHOT: info.words = {16'b0, chan_nxt.bsize};
        SYNC_PACED:   info.words = 32'(chan_nxt.bsize) * 32'(chan_nxt.bcount);
        default:      info.words = '0;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dmarb_irq_regs.sv -----
// Interrupt register: force, enables, master enable and pending flags.
`timescale 1ns / 1ps
`default_nettype none

module dmarb_irq_regs
  import dmarb_pkg::*;
#(
  parameter int NUM_CHANNELS = 7
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire item_t  item,
  input  wire logic   we,
  output logic [31:0] rd_data,
  output logic        status_now,
  output logic        status_nxt
);

  logic [5:0]          spare_r, spare_nxt;
  logic                force_r, force_nxt;
  logic [IRQ_CH_W-1:0] en_r, en_nxt;
  logic                master_r, master_nxt;
  logic [IRQ_CH_W-1:0] flags_r, flags_nxt;
  logic                ch_ok;

  assign ch_ok = item.channel < 3'(NUM_CHANNELS);

  // Compute the register after the word
  always_comb begin
    spare_nxt  = spare_r;
    force_nxt  = force_r;
    en_nxt     = en_r;
    master_nxt = master_r;
    flags_nxt  = flags_r;
    case (item.kind)
      KIND_WRITE: begin
        if (item.target == TGT_IRQ) begin
          spare_nxt  = item.wdata[5:0];
          force_nxt  = item.wdata[15];
          en_nxt     = item.wdata[22:16];
          master_nxt = item.wdata[23];
          flags_nxt  = flags_r & ~item.wdata[30:24];
        end
      end
      KIND_DONE: begin
        if (ch_ok) flags_nxt = flags_r | (en_r & (IRQ_CH_W'(1) << item.channel));
      end
      default: ;
    endcase
  end

  // Hold or advance the register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spare_r  <= '0;
      force_r  <= 1'b0;
      en_r     <= '0;
      master_r <= 1'b0;
      flags_r  <= '0;
    end else if (we) begin
      spare_r  <= spare_nxt;
      force_r  <= force_nxt;
      en_r     <= en_nxt;
      master_r <= master_nxt;
      flags_r  <= flags_nxt;
    end
  end

  assign status_now = irq_status(force_r, master_r, flags_r, en_r);
  assign status_nxt = irq_status(force_nxt, master_nxt, flags_nxt, en_nxt);
  assign rd_data    = {status_now, flags_r, master_r, en_r, force_r, 9'b0, spare_r};

endmodule

`default_nettype wire

// ----- hw/rtl/dma_register_bank_irq.sv -----
// Top level of the DMA register bank: stage register, register files, result register.
// A word accepted into the stage register moves on into the result register when it advances.
// Throughput: one word per cycle; a stalled full result register stalls the input that cycle.
// The multiply for request-mode transfer size sits between stage and result register.
// Reset (rst_n low, synchronous) clears the register bank and drops both valids.
`timescale 1ns / 1ps
`default_nettype none

module dma_register_bank_irq
  import dmarb_pkg::*;
#(
  parameter int NUM_CHANNELS = 7
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_kind,
  input  wire logic [2:0]  in_target,
  input  wire logic [2:0]  in_channel,
  input  wire logic [31:0] in_write_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_read_data,
  output logic             out_irq_line,
  output logic             out_irq_rise,
  output logic             out_channel_active,
  output logic [31:0]      out_transfer_words,
  output logic             out_direction_from_ram,
  output logic             out_step_down,
  output logic [1:0]       out_sync_mode
);

  logic        s1_v_r, s1_v_nxt;
  item_t       s1_item_r;
  logic        advance;
  logic        accept;
  logic [31:0] dma_ctl_r;
  logic [31:0] chan_rd;
  logic [31:0] irq_rd;
  logic        st_now, st_nxt;
  chan_info_t  info;
  logic [31:0] rd_sel;
  logic        out_v_r;

  // Move the word from the stage register into the result register
  assign advance  = s1_v_r & (~out_v_r | ~out_stall);
  assign in_stall = s1_v_r & ~advance;
  assign accept   = in_valid & ~in_stall;
  assign s1_v_nxt = accept | (s1_v_r & ~advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= '{kind: in_kind, target: in_target, channel: in_channel,
                     wdata: in_write_data};
    end
  end

  dmarb_chan_regs #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_chan (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (s1_item_r),
    .we      (advance),
    .rd_data (chan_rd),
    .info    (info)
  );

  dmarb_irq_regs #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_irq (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (s1_item_r),
    .we         (advance),
    .rd_data    (irq_rd),
    .status_now (st_now),
    .status_nxt (st_nxt)
  );

  // Hold the DMA control word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dma_ctl_r <= '0;
    end else if (advance && s1_item_r.kind == KIND_WRITE && s1_item_r.target == TGT_DMA) begin
      dma_ctl_r <= s1_item_r.wdata;
    end
  end

  // Pick the read value
  always_comb begin
    rd_sel = '0;
    if (s1_item_r.kind == KIND_READ) begin
      case (s1_item_r.target)
        TGT_DMA: rd_sel = dma_ctl_r;
        TGT_IRQ: rd_sel = irq_rd;
        default: rd_sel = chan_rd;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_read_data          <= rd_sel;
      out_irq_line           <= st_nxt;
      out_irq_rise           <= st_nxt & ~st_now;
      out_channel_active     <= info.active;
      out_transfer_words     <= info.words;
      out_direction_from_ram <= info.dir;
      out_step_down          <= info.step;
      out_sync_mode          <= info.sync;
    end
  end

  assign out_valid = out_v_r;

endmodule

`default_nettype wire

// ----- hw/rtl/dmarb_checker.sv -----
// Port-level checker for the DMA register bank, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module dmarb_checker
  import dmarb_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  in_kind,
  input wire logic [2:0]  in_target,
  input wire logic [2:0]  in_channel,
  input wire logic [31:0] in_write_data,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_read_data,
  input wire logic        out_irq_line,
  input wire logic        out_irq_rise,
  input wire logic        out_channel_active,
  input wire logic [31:0] out_transfer_words,
  input wire logic        out_direction_from_ram,
  input wire logic        out_step_down,
  input wire logic [1:0]  out_sync_mode
);

  // A stalled result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data)
      && $stable(out_transfer_words))
    else $error("stalled result word changed");

  // A rise pulse comes only with the line high
  a_rise_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_irq_rise |-> out_irq_line)
    else $error("irq rise without irq line");

  // Sync mode three is never stored
  a_sync_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sync_mode != SYNC_KEEP)
    else $error("reserved sync mode reported");

  // Linked-list mode reports no transfer size
  a_list_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sync_mode == SYNC_LIST |-> out_transfer_words == 32'd0)
    else $error("linked-list transfer size not zero");

  // Manual mode size fits in the block size field
  a_manual_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sync_mode == SYNC_ONESHOT |-> out_transfer_words[31:16] == 16'd0)
    else $error("manual transfer size too wide");

endmodule

bind dma_register_bank_irq dmarb_checker u_dmarb_checker (.*);

`default_nettype wire

// ----- dv/dmarb_monitor.sv -----
// Channel monitor for the DMA register bank: predicts each result word and compares it.
`timescale 1ns / 1ps

module dmarb_monitor
  import dmarb_pkg::*;
#(
  parameter int NUM_CHANNELS = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [2:0]  in_target,
  input  logic [2:0]  in_channel,
  input  logic [31:0] in_write_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_read_data,
  input  logic        out_irq_line,
  input  logic        out_irq_rise,
  input  logic        out_channel_active,
  input  logic [31:0] out_transfer_words,
  input  logic        out_direction_from_ram,
  input  logic        out_step_down,
  input  logic [1:0]  out_sync_mode,
  output int          mismatches,
  output int          replies_due
);

  localparam int REPORT_MAX = 10;

  // One result word as the bank reports it
  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_line;
    logic        irq_rise;
    logic        active;
    logic [31:0] words;
    logic        dir;
    logic        step;
    logic [1:0]  sync;
  } reply_t;

  // Shadow copy of the register bank
  chan_t               chans [NUM_CHANNELS];
  logic [31:0]         dma_word;
  logic [5:0]          irq_spare;
  logic                irq_force_bit;
  logic [IRQ_CH_W-1:0] irq_enables;
  logic                irq_master;
  logic [IRQ_CH_W-1:0] irq_flags;

  reply_t replies [$];
  int     bad_count;

  function automatic logic irq_raised();
    return irq_force_bit | (irq_master & (|(irq_flags & irq_enables)));
  endfunction

  // Apply one bus word to the shadow bank and return the result it should produce
  function automatic reply_t bank_step(input logic [1:0] kind, input logic [2:0] tgt,
                                       input logic [2:0] ch, input logic [31:0] wd);
    logic   ch_ok;
    logic   was_up;
    reply_t r;
    chan_t  c;
    ch_ok  = ch < NUM_CHANNELS;
    was_up = irq_raised();
    r      = '0;
    c      = '0;
    if (ch_ok) begin
      c = chans[ch];
    end
    case (kind)
      KIND_READ: begin
        case (tgt)
          TGT_DMA: r.read_data = dma_word;
          TGT_IRQ: r.read_data = {was_up, irq_flags, irq_master, irq_enables, irq_force_bit,
                                  9'd0, irq_spare};
          TGT_BASE: if (ch_ok) r.read_data = {8'd0, c.base};
          TGT_BLOCK: if (ch_ok) r.read_data = {c.bcount, c.bsize};
          TGT_CHAN: begin
            if (ch_ok) begin
              r.read_data = {1'b0, c.spare, c.trig, 3'd0, c.en, 1'b0, c.cpu_win, 1'b0,
                             c.dma_win, 5'd0, c.sync, c.chop, 6'd0, c.step, c.dir};
            end
          end
          default: r.read_data = '0;
        endcase
      end
      KIND_WRITE: begin
        case (tgt)
          TGT_DMA: dma_word = wd;
          TGT_IRQ: begin
            irq_spare     = wd[5:0];
            irq_force_bit = wd[15];
            irq_enables   = wd[22:16];
            irq_master    = wd[23];
            // acknowledge: ones clear the matching flags
            irq_flags     = irq_flags & ~wd[30:24];
          end
          TGT_BASE: if (ch_ok) c.base = wd[23:0];
          TGT_BLOCK: begin
            c.bsize  = wd[15:0];
            c.bcount = wd[31:16];
          end
          TGT_CHAN: begin
            c.dir  = wd[0];
            c.step = wd[1];
            c.chop = wd[8];
            // keep-mode touches only direction, step and chop
            if (wd[10:9] != SYNC_KEEP) begin
              c.sync    = wd[10:9];
              c.dma_win = wd[18:16];
              c.cpu_win = wd[22:20];
              c.en      = wd[24];
              c.trig    = wd[28];
              c.spare   = wd[30:29];
            end
          end
          default: ;
        endcase
      end
      KIND_DONE: begin
        if (ch_ok) begin
          c.en          = 1'b0;
          c.trig        = 1'b0;
          irq_flags[ch] = irq_flags[ch] | irq_enables[ch];
        end
      end
      default: ;
    endcase
    if (ch_ok) begin
      chans[ch] = c;
    end

    r.irq_line = irq_raised();
    r.irq_rise = !was_up && r.irq_line;
    if (ch_ok) begin
      r.active = c.en && (c.sync != SYNC_ONESHOT || c.trig);
      r.dir    = c.dir;
      r.step   = c.step;
      r.sync   = c.sync;
      case (c.sync)
        SYNC_ONESHOT: r.words = {16'd0, c.bsize};
        SYNC_PACED:   r.words = 32'(c.bsize) * 32'(c.bcount);
        default:      r.words = '0;
      endcase
    end
    return r;
  endfunction

  // Compare accepted results, then queue the prediction for the accepted input word
  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        chans[i] = '0;
      end
      dma_word      = '0;
      irq_spare     = '0;
      irq_force_bit = 1'b0;
      irq_enables   = '0;
      irq_master    = 1'b0;
      irq_flags     = '0;
      replies.delete();
      bad_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_read_data, out_irq_line, out_irq_rise, out_channel_active,
                out_transfer_words, out_direction_from_ram, out_step_down, out_sync_mode};
        if (replies.size() == 0) begin
          bad_count++;
          if (bad_count <= REPORT_MAX) begin
            $display("%0t: result word with nothing predicted: rd=%h", $realtime,
                     out_read_data);
          end
        end else begin
          want = replies.pop_front();
          if (got.read_data != want.read_data || got.irq_line != want.irq_line ||
              got.irq_rise != want.irq_rise || got.active != want.active ||
              got.words != want.words || got.dir != want.dir ||
              got.step != want.step || got.sync != want.sync) begin
            bad_count++;
            if (bad_count <= REPORT_MAX) begin
              $display("%0t: mismatch exp rd=%h irq=%b rise=%b act=%b words=%h dir=%b step=%b sync=%0d",
                       $realtime, want.read_data, want.irq_line, want.irq_rise, want.active,
                       want.words, want.dir, want.step, want.sync);
              $display("%0t:          got rd=%h irq=%b rise=%b act=%b words=%h dir=%b step=%b sync=%0d",
                       $realtime, got.read_data, got.irq_line, got.irq_rise, got.active,
                       got.words, got.dir, got.step, got.sync);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        replies.push_back(bank_step(in_kind, in_target, in_channel, in_write_data));
      end
    end
    mismatches  <= bad_count;
    replies_due <= replies.size();
  end

endmodule

// ----- dv/tb_top.sv -----
// Top of the DMA register bank testbench: clock, reset, stimulus, stall pattern and verdict.
`timescale 1ns / 1ps

module tb_top;
  import dmarb_pkg::*;

  localparam int NCH          = 7;
  localparam int RANDOM_WORDS = 1850;
  localparam int LONG_HOLD    = 150;
  localparam int IDLE_LIMIT   = 2000;
  localparam int SETTLE       = 8;

  // codes outside the defined ranges
  localparam logic [1:0] KIND_SPARE  = 2'd3;
  localparam logic [2:0] TGT_SPARE   = 3'd5;
  localparam logic [2:0] TGT_LAST    = 3'd7;
  localparam logic [2:0] CH_NONE     = 3'd7;

  // register field positions
  localparam int          SYNC_LSB    = 9;
  localparam logic [31:0] CC_EN       = 32'h0100_0000;
  localparam logic [31:0] CC_TRIG     = 32'h1000_0000;
  localparam logic [31:0] IRQ_FORCE   = 32'h0000_8000;
  localparam logic [31:0] IRQ_ENABLES = 32'h007f_0000;
  localparam logic [31:0] IRQ_MASTER  = 32'h0080_0000;
  localparam logic [31:0] IRQ_ACK_ALL = 32'h7f00_0000;
  localparam logic [31:0] IRQ_SPARE   = 32'h0000_003f;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = '0;
  logic [2:0]  in_target = '0;
  logic [2:0]  in_channel = '0;
  logic [31:0] in_write_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_read_data;
  logic        out_irq_line;
  logic        out_irq_rise;
  logic        out_channel_active;
  logic [31:0] out_transfer_words;
  logic        out_direction_from_ram;
  logic        out_step_down;
  logic [1:0]  out_sync_mode;
  logic        hold_results = 1'b0;
  int          mismatches;
  int          replies_due;
  int          idle_cycles = 0;

  always #1 clk = ~clk;

  dma_register_bank_irq #(.NUM_CHANNELS(NCH)) DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_kind                (in_kind),
    .in_target              (in_target),
    .in_channel             (in_channel),
    .in_write_data          (in_write_data),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_read_data          (out_read_data),
    .out_irq_line           (out_irq_line),
    .out_irq_rise           (out_irq_rise),
    .out_channel_active     (out_channel_active),
    .out_transfer_words     (out_transfer_words),
    .out_direction_from_ram (out_direction_from_ram),
    .out_step_down          (out_step_down),
    .out_sync_mode          (out_sync_mode)
  );

  dmarb_monitor #(.NUM_CHANNELS(NCH)) monitor (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_kind                (in_kind),
    .in_target              (in_target),
    .in_channel             (in_channel),
    .in_write_data          (in_write_data),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_read_data          (out_read_data),
    .out_irq_line           (out_irq_line),
    .out_irq_rise           (out_irq_rise),
    .out_channel_active     (out_channel_active),
    .out_transfer_words     (out_transfer_words),
    .out_direction_from_ram (out_direction_from_ram),
    .out_step_down          (out_step_down),
    .out_sync_mode          (out_sync_mode),
    .mismatches             (mismatches),
    .replies_due            (replies_due)
  );

  // Present one word and hold it until the bank takes it; sample the stall mid-cycle
  task automatic offer_word(input logic [1:0] k, input logic [2:0] t, input logic [2:0] c,
                            input logic [31:0] d);
    bit taken;
    in_valid      <= 1'b1;
    in_kind       <= k;
    in_target     <= t;
    in_channel    <= c;
    in_write_data <= d;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_due != 0) @(posedge clk);
  endtask

  // Receiver: stall pattern in segments, plus one long hold-off on request
  initial begin : receiver
    int  mode;
    int  span;
    bit  held;
    held = 1'b0;
    wait (rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 48);
      repeat (span) begin
        if (hold_results && !held) begin
          out_stall <= 1'b1;
          repeat (LONG_HOLD) @(posedge clk);
          held = 1'b1;
        end
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 9) < 3);
          2: out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= ~out_stall;
        endcase
        @(posedge clk);
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    int          sent;
    int          burst;
    int          pick;
    bit          drained_mid;
    logic [1:0]  k;
    logic [2:0]  t;
    logic [2:0]  c;
    logic [31:0] d;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, every register, each special case
    offer_word(KIND_READ, TGT_IRQ, 3'd0, '0);
    offer_word(KIND_WRITE, TGT_BASE, 3'd0, 32'hFFFF_FFFF);
    offer_word(KIND_READ, TGT_BASE, 3'd0, '0);
    offer_word(KIND_WRITE, TGT_BLOCK, 3'd6, 32'hFFFF_FFFF);
    offer_word(KIND_WRITE, TGT_CHAN, 3'd6, CC_EN | (32'(SYNC_PACED) << SYNC_LSB));
    offer_word(KIND_READ, TGT_BLOCK, 3'd6, '0);
    // keep-mode write changes only direction, step and chop
    offer_word(KIND_WRITE, TGT_CHAN, 3'd1, 32'hFFFF_FFFF);
    offer_word(KIND_READ, TGT_CHAN, 3'd1, '0);
    offer_word(KIND_WRITE, TGT_CHAN, 3'd2,
               ~(32'(SYNC_KEEP) << SYNC_LSB) | (32'(SYNC_LIST) << SYNC_LSB));
    offer_word(KIND_READ, TGT_CHAN, 3'd2, '0);
    offer_word(KIND_WRITE, TGT_BLOCK, 3'd3, 32'h0003_0040);
    offer_word(KIND_WRITE, TGT_CHAN, 3'd3, CC_EN | CC_TRIG);
    offer_word(KIND_WRITE, TGT_IRQ, 3'd0, IRQ_MASTER | IRQ_ENABLES | IRQ_SPARE);
    // done on an enabled channel raises its flag and the line
    offer_word(KIND_DONE, TGT_BASE, 3'd3, '0);
    offer_word(KIND_READ, TGT_IRQ, 3'd0, '0);
    offer_word(KIND_WRITE, TGT_IRQ, 3'd0, IRQ_MASTER | IRQ_ENABLES | IRQ_ACK_ALL);
    offer_word(KIND_WRITE, TGT_IRQ, 3'd0, IRQ_FORCE);
    offer_word(KIND_WRITE, TGT_IRQ, 3'd0, '0);
    offer_word(KIND_WRITE, TGT_DMA, 3'd0, 32'hFFFF_FFFF);
    offer_word(KIND_READ, TGT_DMA, 3'd5, '0);
    // out-of-range channel, target and kind
    offer_word(KIND_WRITE, TGT_BASE, CH_NONE, 32'hFFFF_FFFF);
    offer_word(KIND_READ, TGT_BASE, CH_NONE, '0);
    offer_word(KIND_DONE, TGT_BASE, CH_NONE, '0);
    offer_word(KIND_WRITE, TGT_LAST, 3'd0, 32'hFFFF_FFFF);
    offer_word(KIND_READ, TGT_SPARE, 3'd0, '0);
    offer_word(KIND_SPARE, TGT_DMA, 3'd0, 32'hFFFF_FFFF);
    // done with interrupt enables off sets no flag
    offer_word(KIND_DONE, TGT_CHAN, 3'd6, '0);
    wait_drained();

    // Random traffic in bursts; ask the receiver for one long hold-off up front
    hold_results <= 1'b1;
    sent = 0;
    drained_mid = 1'b0;
    while (sent < RANDOM_WORDS) begin
      burst = $urandom_range(1, 16);
      for (int i = 0; i < burst && sent < RANDOM_WORDS; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) k = KIND_READ;
        else if (pick < 75) k = KIND_WRITE;
        else if (pick < 95) k = KIND_DONE;
        else k = KIND_SPARE;
        t = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(TGT_SPARE, TGT_LAST))
                                         : 3'($urandom_range(TGT_BASE, TGT_IRQ));
        c = ($urandom_range(0, 15) == 0) ? CH_NONE : 3'($urandom_range(0, NCH - 1));
        d = $urandom();
        // lean interrupt writes toward master enabled so raised flags drive the line
        if (k == KIND_WRITE && t == TGT_IRQ && $urandom_range(0, 1) == 1) begin
          d = d | IRQ_MASTER;
        end
        offer_word(k, t, c, d);
        sent++;
      end
      if (!drained_mid && sent >= RANDOM_WORDS / 2) begin
        drained_mid = 1'b1;
        wait_drained();
      end else if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && replies_due == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
